### src/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, mode codes and colour arithmetic for the pixel format
// converter.
// ----------------------------------------------------------------------------
`default_nettype none

package pfc_pkg;

  // Mode register codes
  localparam logic [1:0] MODE_YUYV_RGB = 2'd0;
  localparam logic [1:0] MODE_YUYV_YUV = 2'd1;
  localparam logic [1:0] MODE_RGBA_RGB = 2'd2;
  localparam logic [1:0] MODE_BGRA_RGB = 2'd3;
  localparam logic [1:0] MODE_RESET    = MODE_YUYV_RGB;

  // Configuration port
  localparam int         CFG_ADDR_W  = 3;
  localparam int         CFG_DATA_W  = 32;
  localparam logic [0:0] REG_IDX_MODE = 1'b0;

  // Q10 colour arithmetic; 21 bits signed covers every sum
  localparam int ACC_W = 21;
  localparam logic signed [ACC_W-1:0] COEF_RV       = 21'sd1167;
  localparam logic signed [ACC_W-1:0] COEF_GU       = 21'sd406;
  localparam logic signed [ACC_W-1:0] COEF_GV       = 21'sd595;
  localparam logic signed [ACC_W-1:0] COEF_BU       = 21'sd2078;
  localparam logic signed [ACC_W-1:0] CHROMA_OFFSET = 21'sd128;
  localparam logic [7:0]              PIXEL_MAX     = 8'd255;

  typedef struct packed {
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
  } pix_t;

  // floor(acc / 1024) clamped to 0..255
  function automatic logic [7:0] q10_to_byte(input logic signed [ACC_W-1:0] acc);
    logic [7:0] res;
    if (acc[ACC_W-1]) begin
      res = 8'd0;
    end else if (|acc[ACC_W-2:18]) begin
      res = PIXEL_MAX;
    end else begin
      res = acc[17:10];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### src/pixel_format_converter_top.sv
// ----------------------------------------------------------------------------
// pixel_format_converter_top
// Converts 4-byte source words to 24-bit pixels in one of four modes.
// ----------------------------------------------------------------------------
// A source word is taken into an input register and each pixel it yields is
// built by one pass of logic into the output register, one pixel per cycle
// while the output is not stalled. In the YUYV modes a word gives two pixels
// and so stays in the input register until both have gone out. In the RGBA and
// BGRA modes a word gives one pixel and a word is accepted every cycle unless
// the output is stalled. The first pixel of a word moves from the input register
// to the output register once that register is free; its partner follows once
// the first has left. The pixel-per-cycle limit is set by the single output
// register. Write the mode only while no word is in flight.
`default_nettype none

module pixel_format_converter_top
  import pfc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  // source words
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            in_byte0,
  input  wire logic [7:0]            in_byte1,
  input  wire logic [7:0]            in_byte2,
  input  wire logic [7:0]            in_byte3,
  input  wire logic                  in_frame_end,
  // pixels
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [7:0]            out_red_or_y,
  output logic      [7:0]            out_green_or_u,
  output logic      [7:0]            out_blue_or_v,
  output logic                       out_pixel_last,
  output logic                       out_frame_last
);

  logic [1:0] mode;

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  logic       sel_r, sel_nxt;
  logic [7:0] b0_r, b1_r, b2_r, b3_r;
  logic       fe_r;

  // output register
  logic       out_valid_r, out_valid_nxt;
  pix_t       out_pix_r;
  logic       out_plast_r;
  logic       out_flast_r;

  pix_t       pix;
  logic       two_pix;
  logic       pix_last;
  logic       out_free;
  logic       s1_fire;
  logic       s1_done;
  logic       in_accept;

  pfc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode    (mode)
  );

  pfc_convert u_conv (
    .mode   (mode),
    .second (sel_r),
    .byte0  (b0_r),
    .byte1  (b1_r),
    .byte2  (b2_r),
    .byte3  (b3_r),
    .pix    (pix)
  );

  assign two_pix   = (mode == MODE_YUYV_RGB) || (mode == MODE_YUYV_YUV);
  assign pix_last  = !two_pix || sel_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && out_free;
  assign s1_done   = s1_fire && pix_last;
  assign in_stall  = s1_valid_r && !s1_done;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    sel_nxt      = sel_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
      sel_nxt      = 1'b0;
    end else if (s1_done) begin
      s1_valid_nxt = 1'b0;
      sel_nxt      = 1'b0;
    end else if (s1_fire) begin
      sel_nxt      = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      b0_r <= in_byte0;
      b1_r <= in_byte1;
      b2_r <= in_byte2;
      b3_r <= in_byte3;
      fe_r <= in_frame_end;
    end
    if (s1_fire) begin
      out_pix_r   <= pix;
      out_plast_r <= pix_last;
      out_flast_r <= pix_last && fe_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red_or_y   = out_pix_r.c0;
  assign out_green_or_u = out_pix_r.c1;
  assign out_blue_or_v  = out_pix_r.c2;
  assign out_pixel_last = out_plast_r;
  assign out_frame_last = out_flast_r;

  // second slot only ever pending on a held word in a two-pixel mode
  a_sel_two_pix : assert property (@(posedge clk) disable iff (!rst_n)
    sel_r |-> (s1_valid_r && two_pix))
    else $error("second pixel pending outside a two-pixel word");

  // an empty input register never pushes back
  a_no_stall_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with empty input register");

  // first pixel of a pair never carries the frame flag
  a_first_no_frame : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_pixel_last) |-> !out_frame_last)
    else $error("frame_last on first pixel of a pair");

  // once the first pixel of a pair leaves, its partner follows at once
  a_pair_follows : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_pixel_last) |=> (out_valid && out_pixel_last))
    else $error("second pixel of a pair did not follow");

endmodule

`default_nettype wire

### src/pfc_cfg_regs.sv
// ----------------------------------------------------------------------------
// pfc_cfg_regs
// APB-style register slave holding the conversion mode.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_cfg_regs
  import pfc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output logic      [1:0]            mode
);

  logic [1:0] mode_r;
  logic [1:0] mode_nxt;
  logic       wr_mode;

  assign pready  = 1'b1;
  assign wr_mode = psel && penable && pwrite && (paddr[2] == REG_IDX_MODE);

  always_comb begin
    mode_nxt = mode_r;
    if (wr_mode) begin
      mode_nxt = pwdata[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RESET;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_IDX_MODE) begin
      prdata = {{(CFG_DATA_W-2){1'b0}}, mode_r};
    end
  end

  assign mode = mode_r;

endmodule

`default_nettype wire

### src/pfc_convert.sv
// ----------------------------------------------------------------------------
// pfc_convert
// Builds one output pixel from a held source word, the pixel slot and the
// mode: YUV to RGB in Q10, YUV expansion, or alpha drop (with a byte swap for BGRA).
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_convert
  import pfc_pkg::*;
(
  input  wire logic [1:0] mode,
  input  wire logic       second,
  input  wire logic [7:0] byte0,
  input  wire logic [7:0] byte1,
  input  wire logic [7:0] byte2,
  input  wire logic [7:0] byte3,
  output pix_t            pix
);

  logic [7:0]              luma;
  logic signed [ACC_W-1:0] base;
  logic signed [ACC_W-1:0] u_s;
  logic signed [ACC_W-1:0] v_s;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_g;
  logic signed [ACC_W-1:0] acc_b;

  assign luma = second ? byte2 : byte0;
  assign base = $signed({{(ACC_W-18){1'b0}}, luma, 10'b0});
  assign u_s  = $signed({{(ACC_W-8){1'b0}}, byte1}) - CHROMA_OFFSET;
  assign v_s  = $signed({{(ACC_W-8){1'b0}}, byte3}) - CHROMA_OFFSET;

  assign acc_r = base + COEF_RV * v_s;
  assign acc_g = base - COEF_GU * u_s - COEF_GV * v_s;
  assign acc_b = base + COEF_BU * u_s;

  always_comb begin
    unique case (mode)
      MODE_YUYV_RGB: begin
        pix.c0 = q10_to_byte(acc_r);
        pix.c1 = q10_to_byte(acc_g);
        pix.c2 = q10_to_byte(acc_b);
      end
      MODE_YUYV_YUV: begin
        pix.c0 = luma;
        pix.c1 = byte1;
        pix.c2 = byte3;
      end
      MODE_RGBA_RGB: begin
        pix.c0 = byte0;
        pix.c1 = byte1;
        pix.c2 = byte2;
      end
      MODE_BGRA_RGB: begin
        pix.c0 = byte2;
        pix.c1 = byte1;
        pix.c2 = byte0;
      end
      default: begin
        pix = '0;
      end
    endcase
  end

endmodule

`default_nettype wire
